/* design/linear_contrast_stretch_unit_assert.svh */
// assertion macros for the contrast stretch unit
`ifndef LINEAR_CONTRAST_STRETCH_UNIT_ASSERT_SVH
`define LINEAR_CONTRAST_STRETCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define LCS_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// trigger implies the condition in the next cycle
`define LCS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define LCS_ASSERT(label, cond, msg)
`define LCS_ASSERT_NEXT(label, trig, cond, msg)

`endif

`endif

/* design/lcs_pkg.sv */
// shared types and constants of the contrast stretch unit
package lcs_pkg;

    // default pixel width
    localparam int PIXEL_BITS_DEF = 8;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_WAIT
    } t_state;

endpackage

/* design/linear_contrast_stretch_unit.sv */
// min-max linear contrast stretch with a serial restoring divider
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+--------------------------------------
//  input   | i_valid  | o_stall  | i_func, i_pixel_in, i_frame_end
//  output  | o_valid  | i_stall  | o_pixel_out, o_last_out
//
// a measure transaction updates min and max at acceptance.
// a normalize transaction passes through acceptance, a setup state, the
// PIXEL_BITS steps of the shared subtract-and-compare divider and a wait state
// that hands the quotient to the output register (flat or out-of-range pixels skip
// the divider). reset (synchronous, active low) sets min to all ones, max to 0.
// a stalled result waits in the output register; the next input is still taken.
module linear_contrast_stretch_unit #(
    parameter int PIXEL_BITS = lcs_pkg::PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_func,
    input  logic [PIXEL_BITS-1:0] i_pixel_in,
    input  logic                  i_frame_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    output logic                  o_last_out
);

`include "linear_contrast_stretch_unit_assert.svh"

    localparam int CNT_W = $clog2(PIXEL_BITS + 1);
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PIXEL_BITS - 1);

    lcs_pkg::t_state r_state, n_state;

    logic [PIXEL_BITS-1:0]   r_low, n_low;
    logic [PIXEL_BITS-1:0]   r_high, n_high;
    logic [PIXEL_BITS-1:0]   r_pix, n_pix;
    logic                    r_last, n_last;
    logic [PIXEL_BITS-1:0]   r_span, n_span;
    logic [PIXEL_BITS:0]     r_rem, n_rem;
    logic [PIXEL_BITS-1:0]   r_num, n_num;
    logic [PIXEL_BITS-1:0]   r_quot, n_quot;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    logic [PIXEL_BITS-1:0]   r_out_pix, n_out_pix;
    logic                    r_out_last, n_out_last;

    logic                    in_take;
    logic                    out_load;
    logic [PIXEL_BITS-1:0]   diff;
    logic [2*PIXEL_BITS-1:0] prod;
    logic [PIXEL_BITS:0]     trial;
    logic                    fits;

    assign o_stall     = (r_state != lcs_pkg::ST_IDLE);
    assign in_take     = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_last_out  = r_out_last;

    // setup arithmetic: (p - min) * PIX_MAX as a shift and subtract
    assign diff = r_pix - r_low;
    assign prod = {diff, {PIXEL_BITS{1'b0}}} - {{PIXEL_BITS{1'b0}}, diff};

    // shared divider step
    assign trial = {r_rem[PIXEL_BITS-1:0], r_num[PIXEL_BITS-1]};
    assign fits  = (trial >= {1'b0, r_span});

    // result moves to the output register when that register is free or being taken
    assign out_load = (r_state == lcs_pkg::ST_WAIT) && (!r_out_valid || !i_stall);

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcs_pkg::ST_IDLE;
            r_low       <= PIX_MAX;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low       <= n_low;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
        end
        r_pix      <= n_pix;
        r_last     <= n_last;
        r_span     <= n_span;
        r_rem      <= n_rem;
        r_num      <= n_num;
        r_quot     <= n_quot;
        r_cnt      <= n_cnt;
        r_out_pix  <= n_out_pix;
        r_out_last <= n_out_last;
    end

    // sequencer and next values
    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_high      = r_high;
        n_pix       = r_pix;
        n_last      = r_last;
        n_span      = r_span;
        n_rem       = r_rem;
        n_num       = r_num;
        n_quot      = r_quot;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_pix   = r_out_pix;
        n_out_last  = r_out_last;

        // output register drains when taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lcs_pkg::ST_IDLE: begin
                if (in_take) begin
                    if (i_func) begin
                        n_pix   = i_pixel_in;
                        n_last  = i_frame_end;
                        n_state = lcs_pkg::ST_SETUP;
                    end else begin
                        // measure transaction: running min and max
                        if (i_pixel_in < r_low) begin
                            n_low = i_pixel_in;
                        end
                        if (i_pixel_in > r_high) begin
                            n_high = i_pixel_in;
                        end
                    end
                end
            end
            lcs_pkg::ST_SETUP: begin
                n_span = r_high - r_low;
                n_rem  = {1'b0, prod[2*PIXEL_BITS-1:PIXEL_BITS]};
                n_num  = prod[PIXEL_BITS-1:0];
                n_cnt  = '0;
                priority if (r_high <= r_low || r_pix <= r_low) begin
                    // flat or empty range, or pixel at or below min
                    n_quot  = '0;
                    n_state = lcs_pkg::ST_WAIT;
                end else if (r_pix >= r_high) begin
                    n_quot  = PIX_MAX;
                    n_state = lcs_pkg::ST_WAIT;
                end else begin
                    n_quot  = '0;
                    n_state = lcs_pkg::ST_DIV;
                end
            end
            lcs_pkg::ST_DIV: begin
                // one quotient bit per cycle
                n_rem  = fits ? (trial - {1'b0, r_span}) : trial;
                n_num  = r_num << 1;
                n_quot = (r_quot << 1) | {{(PIXEL_BITS-1){1'b0}}, fits};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = lcs_pkg::ST_WAIT;
                end
            end
            lcs_pkg::ST_WAIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_quot;
                    n_out_last  = r_last;
                    // end of frame returns the range to its reset values
                    if (r_last) begin
                        n_low  = PIX_MAX;
                        n_high = '0;
                    end
                    n_state = lcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lcs_pkg::ST_IDLE;
            end
        endcase
    end

    // range is either in reset form or ordered
    `LCS_ASSERT(a_range_order, (r_low <= r_high) || (r_low == PIX_MAX && r_high == '0), "bad range")
    // divider remainder stays below the divisor
    `LCS_ASSERT(a_rem_bound, (r_state != lcs_pkg::ST_DIV) || (r_rem < {1'b0, r_span}), "bad remainder")
    // a finished quotient shows up on the output next cycle
    `LCS_ASSERT_NEXT(a_result_out, out_load, o_valid && (o_pixel_out == $past(r_quot)), "result lost")
    // measure transactions never leave the idle state
    `LCS_ASSERT_NEXT(a_measure_idle, in_take && !i_func, r_state == lcs_pkg::ST_IDLE, "measure left idle")

endmodule
